@@ rtl/aob_pkg.sv @@
// Package for the alpha over blend unit: widths, pixel types and constants.
// No dependencies.
package aob_pkg;

    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned DEN_W   = 17;
    localparam int unsigned NUM_W   = 25;
    localparam int unsigned QBITS   = 8;
    localparam logic [CHAN_W-1:0] FULL_COVER = 8'd255;

    typedef struct packed {
        logic [CHAN_W-1:0] bottom_red;
        logic [CHAN_W-1:0] bottom_green;
        logic [CHAN_W-1:0] bottom_blue;
        logic [CHAN_W-1:0] bottom_alpha;
        logic [CHAN_W-1:0] top_red;
        logic [CHAN_W-1:0] top_green;
        logic [CHAN_W-1:0] top_blue;
        logic [CHAN_W-1:0] top_alpha;
    } t_pix_in;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_alpha;
        logic              fully_clear;
    } t_pix_out;

    // Word handed from one divider cell to the next.
    typedef struct packed {
        logic                valid;
        logic [NUM_W:0]      rem_r;
        logic [NUM_W:0]      rem_g;
        logic [NUM_W:0]      rem_b;
        logic [QBITS-1:0]    q_r;
        logic [QBITS-1:0]    q_g;
        logic [QBITS-1:0]    q_b;
        logic [DEN_W:0]      den2;
        logic [CHAN_W-1:0]   alpha;
        logic                clear;
    } t_cell;

endpackage

@@ rtl/aob_if.sv @@
// Valid/ready channel interfaces for the alpha over blend unit.
// Depends on aob_pkg.
interface aob_in_if;
    logic            valid;
    logic            ready;
    aob_pkg::t_pix_in data;
    modport source  (output valid, output data, input ready);
    modport sink    (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

interface aob_out_if;
    logic             valid;
    logic             ready;
    aob_pkg::t_pix_out data;
    modport source  (output valid, output data, input ready);
    modport sink    (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

@@ rtl/aob_front.sv @@
// Front stage: forms weights, denominator, numerators and coverage.
// Depends on aob_pkg.
module aob_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  aob_pkg::t_pix_in   i_pix,
    output aob_pkg::t_cell     o_cell
);
    logic [15:0] r_top_w, r_bot_w;
    logic [7:0]  r_tr, r_tg, r_tb, r_br, r_bg, r_bb;
    logic        r_v1;
    logic [7:0]  w_inv;
    logic [aob_pkg::DEN_W-1:0] w_den;
    logic [aob_pkg::DEN_W+6:0] w_acov;
    logic [aob_pkg::DEN_W:0]   w_dr;
    logic [8:0]                w_q0;
    logic [aob_pkg::DEN_W+1:0] w_back;
    aob_pkg::t_cell r_cell;

    function automatic logic [aob_pkg::NUM_W:0] numer(input logic [7:0] t, input logic [7:0] b,
                                                      input logic [15:0] tw, input logic [15:0] bw);
        logic [23:0] s;
        s = t * tw + b * bw;
        return {1'b0, s, 1'b0};
    endfunction

    assign w_inv = aob_pkg::FULL_COVER - i_pix.top_alpha;

    // Stage 1: the two weight products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            r_top_w <= i_pix.top_alpha * aob_pkg::FULL_COVER;
            r_bot_w <= i_pix.bottom_alpha * w_inv;
            r_tr <= i_pix.top_red;   r_br <= i_pix.bottom_red;
            r_tg <= i_pix.top_green; r_bg <= i_pix.bottom_green;
            r_tb <= i_pix.top_blue;  r_bb <= i_pix.bottom_blue;
        end
    end

    assign w_den = {1'b0, r_top_w} + {1'b0, r_bot_w};
    // (D + 127) / 255 by reciprocal: x*257 >> 16 is the true quotient or one
    // below it for every x in range, so one compare of the remainder fixes it.
    assign w_dr   = {1'b0, w_den} + 18'd127;
    assign w_acov = {7'd0, w_dr[aob_pkg::DEN_W-1:0]} * 24'd257;
    assign w_q0   = {1'b0, w_acov[23:16]};
    assign w_back = {10'd0, w_q0} * 19'd255;

    // Stage 2: numerators doubled, doubled denominator, coverage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell.valid <= r_v1;
        end
        if (i_en) begin
            r_cell.rem_r <= numer(r_tr, r_br, r_top_w, r_bot_w) + {9'd0, w_den};
            r_cell.rem_g <= numer(r_tg, r_bg, r_top_w, r_bot_w) + {9'd0, w_den};
            r_cell.rem_b <= numer(r_tb, r_bb, r_top_w, r_bot_w) + {9'd0, w_den};
            r_cell.q_r   <= '0;
            r_cell.q_g   <= '0;
            r_cell.q_b   <= '0;
            r_cell.den2  <= {w_den, 1'b0};
            r_cell.clear <= (w_den == '0);
            if ({1'b0, w_dr} - w_back >= 19'd255) begin
                r_cell.alpha <= w_q0[7:0] + 8'd1;
            end else begin
                r_cell.alpha <= w_q0[7:0];
            end
        end
    end

    assign o_cell = r_cell;
endmodule

@@ rtl/aob_div_cell.sv @@
// One restoring-division cell: settles one quotient bit of each channel.
// Depends on aob_pkg.
module aob_div_cell #(
    parameter int unsigned BIT = 7
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  aob_pkg::t_cell  i_cell,
    output aob_pkg::t_cell  o_cell
);
    aob_pkg::t_cell r_cell, n_cell;
    logic [aob_pkg::NUM_W+1:0] w_sh;

    assign w_sh = {{(aob_pkg::NUM_W+1-aob_pkg::DEN_W){1'b0}}, i_cell.den2} << BIT;

    always_comb begin
        n_cell = i_cell;
        if ({1'b0, i_cell.rem_r} >= w_sh) begin
            n_cell.rem_r = i_cell.rem_r - w_sh[aob_pkg::NUM_W:0];
            n_cell.q_r[BIT] = 1'b1;
        end
        if ({1'b0, i_cell.rem_g} >= w_sh) begin
            n_cell.rem_g = i_cell.rem_g - w_sh[aob_pkg::NUM_W:0];
            n_cell.q_g[BIT] = 1'b1;
        end
        if ({1'b0, i_cell.rem_b} >= w_sh) begin
            n_cell.rem_b = i_cell.rem_b - w_sh[aob_pkg::NUM_W:0];
            n_cell.q_b[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell.valid <= n_cell.valid;
        end
        if (i_en) begin
            r_cell.rem_r <= n_cell.rem_r;
            r_cell.rem_g <= n_cell.rem_g;
            r_cell.rem_b <= n_cell.rem_b;
            r_cell.q_r   <= n_cell.q_r;
            r_cell.q_g   <= n_cell.q_g;
            r_cell.q_b   <= n_cell.q_b;
            r_cell.den2  <= n_cell.den2;
            r_cell.alpha <= n_cell.alpha;
            r_cell.clear <= n_cell.clear;
        end
    end

    assign o_cell = r_cell;
endmodule

@@ rtl/alpha_over_blend_unit.sv @@
// Top level of the alpha over blend unit: front stage, divider cell row, output register.
// Depends on aob_pkg, aob_if, aob_front and aob_div_cell.
//
// Usage: pixel beats arrive on i_pix (bottom and top RGBA8) and leave on
// o_pix (composited RGBA8 plus the fully_clear flag). Both channels use
// valid/ready; a beat moves when both are high.
// The unit accepts one beat per cycle while the receiver does not stall. The
// front stage forms the weights, the denominator and the numerators, then eight identical
// divider cells each settle one quotient bit per channel and hand the
// partial remainders to their neighbor, and one output register follows.
// When both coverages are zero, the colors and alpha come out as zero and
// fully_clear is set.
// The pipeline advances whenever the output register is empty or being
// drained; when the receiver stalls, the pipeline freezes in place and
// i_pix.ready drops, so no beat is lost. A valid output is held stable until
// it is taken.
// Reset (synchronous, active low) clears all valid flags; data registers
// are not reset. There is no configuration.
module alpha_over_blend_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    aob_in_if.sink    i_pix,
    aob_out_if.source o_pix
);
    localparam int unsigned NCELL = aob_pkg::QBITS;

    aob_pkg::t_cell w_chain [NCELL+1];
    logic           w_en;
    logic           r_ovalid;
    aob_pkg::t_pix_out r_odata;

    // The whole pipe moves together; the last cell only empties into the
    // output register when that register is free or draining.
    assign w_en        = !r_ovalid || o_pix.ready;
    assign i_pix.ready = w_en;

    aob_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_pix.valid),
        .i_pix   (i_pix.data),
        .o_cell  (w_chain[0])
    );

    // Cell k settles quotient bit NCELL-1-k, most significant first.
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        aob_div_cell #(.BIT(NCELL-1-k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_cell  (w_chain[k]),
            .o_cell  (w_chain[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_en) begin
            r_ovalid <= w_chain[NCELL].valid;
        end
        if (w_en) begin
            if (w_chain[NCELL].clear) begin
                r_odata <= '{out_red: '0, out_green: '0, out_blue: '0,
                             out_alpha: '0, fully_clear: 1'b1};
            end else begin
                r_odata <= '{out_red: w_chain[NCELL].q_r, out_green: w_chain[NCELL].q_g,
                             out_blue: w_chain[NCELL].q_b, out_alpha: w_chain[NCELL].alpha,
                             fully_clear: 1'b0};
            end
        end
    end

    assign o_pix.valid = r_ovalid;
    assign o_pix.data  = r_odata;

    // A stalled output beat keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !o_pix.ready |=> r_ovalid && $stable(r_odata))
        else $error("output beat changed while stalled");
    // The input is refused exactly while the output is stalled.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.ready == (!r_ovalid || o_pix.ready))
        else $error("input ready out of step with output stall");
    // A clear beat carries zero coverage.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_odata.fully_clear |-> r_odata.out_alpha == '0)
        else $error("clear beat with nonzero alpha");
endmodule
